// ===== design/integer_to_ascii_radix_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for integer_to_ascii_radix
// Implication checks, same cycle and next cycle, with reset disable.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_DEFINES_SVH

`ifndef ASSERT_OFF
`define ITAR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itar assertion failed");
`define ITAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itar assertion failed");
`else
`define ITAR_ASSERT_NOW(label, clk, rst, ante, cons)
`define ITAR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/itar_pkg.sv =====
// ----------------------------------------------------------------------------
// itar_pkg
// Shared types, codes and the digit-to-character function of the converter.
// ----------------------------------------------------------------------------
package itar_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int IN_VALUE_WIDTH     = 32;
   localparam int CMD_WIDTH          = 2;
   localparam int CHAR_WIDTH         = 8;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO    = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] ASCII_LOWER_A = 8'd97;
   localparam logic [3:0]            DIGIT_TEN     = 4'd10;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_DEC  = 2'd0,
      CMD_HEX  = 2'd1,
      CMD_BIN  = 2'd2,
      CMD_NONE = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      RADIX_DEC,
      RADIX_HEX,
      RADIX_BIN
   } radix_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [3:0] d);
      logic [CHAR_WIDTH-1:0] d_ext;
      d_ext = {4'b0000, d};
      if (d < DIGIT_TEN) begin
         digit_char = ASCII_ZERO + d_ext;
      end else begin
         digit_char = ASCII_LOWER_A + d_ext - {4'b0000, DIGIT_TEN};
      end
   endfunction

endpackage

// ===== design/itar_front.sv =====
// ----------------------------------------------------------------------------
// itar_front
// Accepts request items, decodes the radix command and drops empty commands.
// ----------------------------------------------------------------------------
module itar_front
   import itar_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [IN_VALUE_WIDTH-1:0] req_value,
   input  logic [CMD_WIDTH-1:0]      req_command,
   input  queue_status_type          queue_status,
   output logic                      push,
   output logic [VALUE_BITS-1:0]     push_value,
   output radix_type                 push_radix
);

   command_type cmd;

   assign cmd       = command_type'(req_command);
   assign req_ready = !queue_status.full;
   assign push      = req_valid && req_ready && (cmd != CMD_NONE);

   generate
      if (VALUE_BITS <= IN_VALUE_WIDTH) begin : g_trunc
         assign push_value = req_value[VALUE_BITS-1:0];
      end else begin : g_extend
         assign push_value = VALUE_BITS'(req_value);
      end
   endgenerate

   always_comb begin
      case (cmd)
         CMD_DEC: push_radix = RADIX_DEC;
         CMD_HEX: push_radix = RADIX_HEX;
         CMD_BIN: push_radix = RADIX_BIN;
         default: push_radix = RADIX_DEC;
      endcase
   end

endmodule

// ===== design/itar_queue.sv =====
// ----------------------------------------------------------------------------
// itar_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module itar_queue
   import itar_pkg::*;
#(
   parameter int WIDTH = VALUE_BITS_DEFAULT + 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type queue_status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign queue_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign queue_status.empty = (count_ff == '0);
   assign pop_data           = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/itar_back.sv =====
// ----------------------------------------------------------------------------
// itar_back
// Converts one queued value to digits and sends them out, top digit first.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_radix_defines.svh"

module itar_back
   import itar_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  queue_status_type      queue_status,
   input  logic [VALUE_BITS-1:0] pop_value,
   input  radix_type             pop_radix,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAR_WIDTH-1:0] rsp_character,
   output logic                  rsp_last
);

   localparam int DEC_DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;
   localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
   localparam int DEC_BITS   = DEC_DIGITS * 4;
   localparam int HEX_BITS   = HEX_DIGITS * 4;
   localparam int SR_BITS    = (DEC_BITS > HEX_BITS) ? DEC_BITS : HEX_BITS;
   localparam int DEC_SHIFT  = SR_BITS - DEC_BITS;
   localparam int HEX_SHIFT  = SR_BITS - HEX_BITS;
   localparam int BIN_SHIFT  = SR_BITS - VALUE_BITS;
   localparam int CNT_W      = $clog2(VALUE_BITS + 1);

   back_state_type        state_ff, state_in;
   radix_type             radix_ff, radix_in;
   logic [SR_BITS-1:0]    sr_ff, sr_in;
   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  lead_ff, lead_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0] rsp_character_ff, rsp_character_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [DEC_BITS-1:0]   bcd_cur;
   logic [DEC_BITS-1:0]   bcd_adj;
   logic [DEC_BITS-1:0]   bcd_next;
   logic [3:0]            digit;
   logic [SR_BITS-1:0]    sr_shifted;
   logic                  last_digit;
   logic                  out_free;
   logic                  emit;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign last_digit = (cnt_ff == CNT_W'(1));
   assign bcd_cur    = sr_ff[SR_BITS-1 -: DEC_BITS];
   assign bcd_next   = {bcd_adj[DEC_BITS-2:0], bin_ff[VALUE_BITS-1]};
   assign digit      = (radix_ff == RADIX_BIN) ? {3'b000, sr_ff[SR_BITS-1]}
                                               : sr_ff[SR_BITS-1 -: 4];
   assign sr_shifted = (radix_ff == RADIX_BIN) ? {sr_ff[SR_BITS-2:0], 1'b0}
                                               : {sr_ff[SR_BITS-5:0], 4'b0000};

   always_comb begin
      logic [3:0] dd_digit;
      for (int i = 0; i < DEC_DIGITS; i++) begin
         dd_digit = bcd_cur[i*4 +: 4];
         bcd_adj[i*4 +: 4] = (dd_digit >= 4'd5) ? dd_digit + 4'd3 : dd_digit;
      end
   end

   always_comb begin
      state_in         = state_ff;
      radix_in         = radix_ff;
      sr_in            = sr_ff;
      bin_in           = bin_ff;
      cnt_in           = cnt_ff;
      lead_in          = lead_ff;
      pop              = 1'b0;
      emit             = 1'b0;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_status.empty) begin
               pop      = 1'b1;
               radix_in = pop_radix;
               lead_in  = 1'b1;
               case (pop_radix)
                  RADIX_DEC: begin
                     bin_in   = pop_value;
                     sr_in    = '0;
                     cnt_in   = CNT_W'(VALUE_BITS);
                     state_in = ST_CONVERT;
                  end
                  RADIX_HEX: begin
                     sr_in    = SR_BITS'(pop_value) << HEX_SHIFT;
                     cnt_in   = CNT_W'(HEX_DIGITS);
                     state_in = ST_EMIT;
                  end
                  default: begin
                     sr_in    = SR_BITS'(pop_value) << BIN_SHIFT;
                     cnt_in   = CNT_W'(VALUE_BITS);
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_CONVERT: begin
            sr_in  = SR_BITS'(bcd_next) << DEC_SHIFT;
            bin_in = {bin_ff[VALUE_BITS-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (last_digit) begin
               cnt_in   = CNT_W'(DEC_DIGITS);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (lead_ff && (digit == 4'd0) && !last_digit) begin
               sr_in  = sr_shifted;
               cnt_in = cnt_ff - CNT_W'(1);
            end else if (out_free) begin
               emit             = 1'b1;
               rsp_valid_in     = 1'b1;
               rsp_character_in = digit_char(digit);
               rsp_last_in      = last_digit;
               lead_in          = 1'b0;
               sr_in            = sr_shifted;
               cnt_in           = cnt_ff - CNT_W'(1);
               if (last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      radix_ff         <= radix_in;
      sr_ff            <= sr_in;
      bin_ff           <= bin_in;
      cnt_ff           <= cnt_in;
      lead_ff          <= lead_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   `ITAR_ASSERT_NOW(a_convert_is_dec, clock, reset, state_ff == ST_CONVERT, radix_ff == RADIX_DEC)
   `ITAR_ASSERT_NOW(a_emit_cnt_nonzero, clock, reset, state_ff == ST_EMIT, cnt_ff != '0)
   `ITAR_ASSERT_NOW(a_dec_digit_range, clock, reset, emit && radix_ff == RADIX_DEC, digit < DIGIT_TEN)
   `ITAR_ASSERT_NEXT(a_last_to_idle, clock, reset, emit && last_digit, state_ff == ST_IDLE && rsp_last_ff)
   `ITAR_ASSERT_NEXT(a_pop_leaves_idle, clock, reset, pop, state_ff != ST_IDLE)

endmodule

// ===== design/integer_to_ascii_radix.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix: value to ASCII digits, decimal, hex or binary
// The back takes one item at a time; decimal items are first converted to BCD,
// and leading zeros are skipped before the first character; sync reset.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix
   import itar_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [IN_VALUE_WIDTH-1:0] req_value,
   input  logic [CMD_WIDTH-1:0]      req_command,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [CHAR_WIDTH-1:0]     rsp_character,
   output logic                      rsp_last
);

   localparam int ENTRY_W = VALUE_BITS + 2;

   queue_status_type      queue_status;
   logic                  push;
   logic [VALUE_BITS-1:0] push_value;
   radix_type             push_radix;
   logic                  pop;
   logic [ENTRY_W-1:0]    pop_data;
   logic [VALUE_BITS-1:0] pop_value;
   radix_type             pop_radix;

   assign pop_value = pop_data[VALUE_BITS-1:0];
   assign pop_radix = radix_type'(pop_data[ENTRY_W-1 -: 2]);

   itar_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_value    (req_value),
      .req_command  (req_command),
      .queue_status (queue_status),
      .push         (push),
      .push_value   (push_value),
      .push_radix   (push_radix)
   );

   itar_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_data    ({push_radix, push_value}),
      .pop          (pop),
      .pop_data     (pop_data),
      .queue_status (queue_status)
   );

   itar_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_status  (queue_status),
      .pop_value     (pop_value),
      .pop_radix     (pop_radix),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== tb/ascii_digit_checker.sv =====
// ----------------------------------------------------------------------------
// ascii_digit_checker
// Watches both channels of the converter. Each accepted item is expanded into
// its expected digit characters, and each accepted character is compared,
// field by field, with the oldest one still waiting.
// ----------------------------------------------------------------------------
module ascii_digit_checker
   import itar_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [IN_VALUE_WIDTH-1:0] req_value,
   input  logic [CMD_WIDTH-1:0]      req_command,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [CHAR_WIDTH-1:0]     rsp_character,
   input  logic                      rsp_last,
   output int                        fail_count,
   output int                        pending_count
);

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  last;
   } digit_char_type;

   digit_char_type awaited_chars[$];

   function automatic void expand_digits(input logic [IN_VALUE_WIDTH-1:0] value,
                                         input command_type cmd);
      logic [63:0]           rest;
      logic [63:0]           base;
      logic [63:0]           digit;
      logic [CHAR_WIDTH-1:0] text[$];
      digit_char_type        entry;
      rest = 64'(value);
      if (VALUE_BITS < 64) begin
         rest = rest & ((64'd1 << VALUE_BITS) - 64'd1);
      end
      case (cmd)
         CMD_DEC: base = 64'd10;
         CMD_HEX: base = 64'd16;
         CMD_BIN: base = 64'd2;
         default: return;
      endcase
      do begin
         digit = rest % base;
         rest  = rest / base;
         if (digit < 64'd10) begin
            text.push_front(ASCII_ZERO + 8'(digit));
         end else begin
            text.push_front(ASCII_LOWER_A + 8'(digit - 64'd10));
         end
      end while (rest != 64'd0);
      foreach (text[i]) begin
         entry.character = text[i];
         entry.last      = (i == text.size() - 1);
         awaited_chars.push_back(entry);
      end
   endfunction

   always @(posedge clock) begin : watch
      digit_char_type want;
      int             fails;
      fails = fail_count;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expand_digits(req_value, command_type'(req_command));
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_chars.size() == 0) begin
               $display("%0t: unexpected character: expected none, actual %h last %b",
                        $time, rsp_character, rsp_last);
               fails++;
            end else begin
               want = awaited_chars.pop_front();
               if (rsp_character !== want.character) begin
                  $display("%0t: character mismatch: expected %h, actual %h",
                           $time, want.character, rsp_character);
                  fails++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last mismatch: expected %b, actual %b",
                           $time, want.last, rsp_last);
                  fails++;
               end
            end
         end
      end
      fail_count    <= fails;
      pending_count <= awaited_chars.size();
   end

endmodule

// ===== tb/tb_integer_to_ascii_radix.sv =====
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_radix
// Drives directed and random values in all radix commands through the
// converter, with bursty input, a stalling receiver and one long hold-off,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_radix;
   import itar_pkg::*;

   localparam int VALUE_BITS      = VALUE_BITS_DEFAULT;
   localparam int RANDOM_ITEMS    = 400;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int CYCLE_LIMIT     = 1000000;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   logic [IN_VALUE_WIDTH-1:0] req_value   = '0;
   logic [CMD_WIDTH-1:0]      req_command = CMD_DEC;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   logic [CHAR_WIDTH-1:0]     rsp_character;
   logic                      rsp_last;
   logic                      hold_off_go = 1'b0;

   int fail_count;
   int pending_count;
   int burst_left = 0;
   int cycle_count = 0;

   always #6 clock = ~clock;

   integer_to_ascii_radix #(
      .VALUE_BITS(VALUE_BITS)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_value    (req_value),
      .req_command  (req_command),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_character(rsp_character),
      .rsp_last     (rsp_last)
   );

   ascii_digit_checker #(
      .VALUE_BITS(VALUE_BITS)
   ) checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_value    (req_value),
      .req_command  (req_command),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_character(rsp_character),
      .rsp_last     (rsp_last),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   task automatic send_item(input logic [IN_VALUE_WIDTH-1:0] value,
                            input command_type cmd);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_value   <= value;
      req_command <= cmd;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [IN_VALUE_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $urandom() >> $urandom_range(0, 31);
         2: return $urandom_range(0, 20);
         default: return 32'hffff_ffff << $urandom_range(0, 31);
      endcase
   endfunction

   function automatic command_type pick_command();
      case ($urandom_range(0, 9))
         0, 1, 2: return CMD_DEC;
         3, 4, 5: return CMD_HEX;
         6, 7, 8: return CMD_BIN;
         default: return CMD_NONE;
      endcase
   endfunction

   initial begin : cycle_watch
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : receiver
      int hold_count;
      int mode;
      int mode_left;
      hold_count = 0;
      mode       = 0;
      mode_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_off_go && hold_count < HOLD_OFF_CYCLES) begin
            hold_count++;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      logic [IN_VALUE_WIDTH-1:0] edge_values[$];
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // zero, all ones and digit-boundary values
      send_item(32'd0, CMD_DEC);
      send_item(32'd0, CMD_HEX);
      send_item(32'd0, CMD_BIN);
      send_item(32'hffff_ffff, CMD_DEC);
      send_item(32'hffff_ffff, CMD_HEX);
      send_item(32'hffff_ffff, CMD_BIN);
      send_item(32'd0, CMD_NONE);
      send_item(32'hffff_ffff, CMD_NONE);
      send_item(32'h1234_abcd, CMD_NONE);
      edge_values = '{32'd1, 32'd9, 32'd10, 32'd15, 32'd16, 32'h8000_0000,
                      32'd999_999_999, 32'd1_000_000_000};
      foreach (edge_values[i]) begin
         send_item(edge_values[i], command_type'(i % 3));
      end
      send_item(32'habcd_ef01, CMD_HEX);
      send_item(32'h5555_5555, CMD_BIN);
      send_item(32'haaaa_aaaa, CMD_BIN);
      send_item(32'd4_294_967_294, CMD_DEC);

      // offer a back-to-back burst while the receiver holds off, then random bursts
      hold_off_go <= 1'b1;
      burst_left = 12;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         send_item(pick_value(), pick_command());
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (2 * VALUE_BITS + 16) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
